### sv/periodic_oneshot_timer_list_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic / one-shot timer list
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_LIST_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_LIST_DEFINES_SVH

// Check that an expression holds at every clock edge outside reset.
`define POTL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define POTL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define POTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/potl_pkg.sv
// ---------------------------------------------------------------------------
// potl_pkg
// Types and constants shared by the timer list memory, result stage and top.
// ---------------------------------------------------------------------------
package potl_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_FIRED    = 2'd0,
    ST_ADDED    = 2'd1,
    ST_REJECTED = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] interval;
    logic [31:0] stamp;
    logic        oneshot;
  } entry_t;

  // Requests from the scan control to the result stage
  typedef struct packed {
    logic        single;        // add outcome, a complete transaction
    status_t     single_status;
    logic        fire;          // one timer fired during a tick
    logic [7:0]  fire_tag;
    logic        finish;        // tick scan complete
  } res_cmd_t;

  typedef struct packed {
    logic pend_vld;             // a result is held back in the pending stage
    logic can_fire;             // a new firing can be taken this cycle
  } res_st_t;

endpackage

### sv/periodic_oneshot_timer_list.sv
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_list
// Ordered list of periodic and one-shot timers held in a single entry memory.
// ---------------------------------------------------------------------------
// An add transaction appends a timer (tag, interval, one-shot flag) stamped
// with in_now_ms. It returns one result, "added", or "rejected" when all
// TimerSlots entries are in use. The entry is written when the add is taken,
// and no new input is taken until its result has passed from the pending
// stage to the output register. A tick transaction scans the stored timers
// in list order against one time value. The entry memory has one read and
// one write port, so the scan walks one entry per clock behind a registered
// read, and the final result passes through the pending stage to the output
// register. The scan pauses while the result channel holds back a firing,
// and no new transaction is taken while a final result waits in the pending
// stage. Every timer whose wrapping elapsed time reaches its interval is
// restamped and its tag is returned. Fired one-shot timers are dropped and
// the list closes up in order during the same pass. At most MAX_RESULTS
// timers fire per tick; later ones wait for the next tick. A tick with
// nothing due returns one "none" result. The final result of each
// transaction carries out_last. No entry clearing is needed after reset.
// ---------------------------------------------------------------------------
`include "periodic_oneshot_timer_list_defines.svh"

module periodic_oneshot_timer_list #(
  parameter  int TimerSlots = potl_pkg::TIMER_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_timer_tag,
  input  logic [31:0] in_interval_ms,
  input  logic        in_one_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fired_tag,
  output logic        out_last
);
  import potl_pkg::*;

  localparam int IdxW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int CntW = $clog2(TimerSlots + 1);
  localparam int NumW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;     // timers in the list
  logic [CntW-1:0] idx_r, idx_nxt;     // next entry to read
  logic [CntW-1:0] w_r, w_nxt;         // next slot to write back (compaction)
  logic [NumW-1:0] n_r, n_nxt;         // firings so far in this tick
  logic [31:0]     now_r, now_nxt;
  logic            ev_vld_r, ev_vld_nxt;

  logic            accept;
  logic            full;
  logic            issue;
  logic            due;
  logic            ev_go;
  logic            keep;
  logic            scan_done;
  logic [31:0]     elapsed;

  logic            rd_en;
  entry_t          rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  res_cmd_t        res_cmd;
  res_st_t         res_st;

  // Take a new transaction only when idle and the pending result has drained
  assign in_ready = (state_r == S_IDLE) && !res_st.pend_vld;
  assign accept   = in_valid && in_ready;
  assign full     = (cnt_r == CntW'(TimerSlots));

  // Evaluate the entry held in the read data register
  assign elapsed  = now_r - rd_data.stamp;
  assign due      = (elapsed >= rd_data.interval) && (n_r < NumW'(MAX_RESULTS));
  // Hold the evaluated entry while the result stage cannot take a firing
  assign ev_go    = ev_vld_r && (!due || res_st.can_fire);
  assign keep     = !(due && rd_data.oneshot);

  // Read ahead only when the evaluation slot frees up; the write pointer never
  // passes the read pointer, so write-back cannot hit an entry still to be read
  assign issue     = (state_r == S_SCAN) && (idx_r < cnt_r) && (!ev_vld_r || ev_go);
  assign rd_en     = issue;
  assign scan_done = (state_r == S_SCAN) && (idx_r == cnt_r) && !ev_vld_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    w_nxt      = w_r;
    n_nxt      = n_r;
    now_nxt    = now_r;
    ev_vld_nxt = ev_vld_r;

    wr_en      = 1'b0;
    wr_addr    = w_r[IdxW-1:0];
    wr_data    = rd_data;

    res_cmd               = '0;
    res_cmd.single_status = ST_ADDED;
    res_cmd.fire_tag      = rd_data.tag;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_TICK) begin
            idx_nxt    = '0;
            w_nxt      = '0;
            n_nxt      = '0;
            now_nxt    = in_now_ms;
            ev_vld_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end else if (full) begin
            res_cmd.single        = 1'b1;
            res_cmd.single_status = ST_REJECTED;
          end else begin
            // Append at the tail, stamped with the current time
            wr_en            = 1'b1;
            wr_addr          = cnt_r[IdxW-1:0];
            wr_data.tag      = in_timer_tag;
            wr_data.interval = in_interval_ms;
            wr_data.stamp    = in_now_ms;
            wr_data.oneshot  = in_one_time;
            cnt_nxt          = cnt_r + CntW'(1);
            res_cmd.single   = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + CntW'(1);
        end
        if (issue) begin
          ev_vld_nxt = 1'b1;
        end else if (ev_go) begin
          ev_vld_nxt = 1'b0;
        end
        if (ev_go) begin
          if (due) begin
            res_cmd.fire = 1'b1;
            n_nxt        = n_r + NumW'(1);
          end
          // Write surviving entries back at the compaction pointer
          if (keep) begin
            wr_en = 1'b1;
            if (due) begin
              wr_data.stamp = now_r;
            end
            w_nxt = w_r + CntW'(1);
          end
        end
        if (scan_done) begin
          res_cmd.finish = 1'b1;
          cnt_nxt        = w_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      idx_r    <= '0;
      w_r      <= '0;
      n_r      <= '0;
      ev_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      w_r      <= w_nxt;
      n_r      <= n_nxt;
      ev_vld_r <= ev_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
  end

  potl_mem #(
    .Slots (TimerSlots)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IdxW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  potl_res u_res (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (res_cmd),
    .st            (res_st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_fired_tag (out_fired_tag),
    .out_last      (out_last)
  );

  // List never grows beyond its storage
  `POTL_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CntW'(TimerSlots), "timer count exceeds slots")
  // Compaction pointer never overtakes the read pointer during a scan
  `POTL_ASSERT_IMPL(a_wr_behind_rd, state_r == S_SCAN, w_r <= idx_r, "write-back passed read")
  // Firings per tick stay within the cap
  `POTL_ASSERT_ALWAYS(a_fire_cap, n_r <= NumW'(MAX_RESULTS), "too many firings in one tick")
  // Only a firing may be followed by further results of the same transaction
  `POTL_ASSERT_IMPL(a_single_last, out_valid && out_status != ST_FIRED, out_last, "lone result not last")

endmodule

### sv/potl_mem.sv
// ---------------------------------------------------------------------------
// potl_mem
// Timer entry store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module potl_mem #(
  parameter  int Slots = potl_pkg::TIMER_SLOTS,
  localparam int IdxW  = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IdxW-1:0]  rd_addr,
  output potl_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [IdxW-1:0]  wr_addr,
  input  potl_pkg::entry_t wr_data
);
  import potl_pkg::*;

  entry_t entry_mem [Slots];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/potl_res.sv
// ---------------------------------------------------------------------------
// potl_res
// Result stage: a pending slot that holds the latest firing until its last
// flag is known, followed by the output register.
// ---------------------------------------------------------------------------
module potl_res (
  input  logic               clk,
  input  logic               rst_n,
  input  potl_pkg::res_cmd_t cmd,
  output potl_pkg::res_st_t  st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_fired_tag,
  output logic               out_last
);
  import potl_pkg::*;

  logic       pend_vld_r, pend_vld_nxt;
  status_t    pend_status_r, pend_status_nxt;
  logic [7:0] pend_tag_r, pend_tag_nxt;
  logic       pend_last_r, pend_last_nxt;

  logic       out_vld_r, out_vld_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [7:0] out_tag_r, out_tag_nxt;
  logic       out_last_r, out_last_nxt;

  logic       out_free;
  logic       move;

  assign out_free = !out_vld_r || out_ready;
  // Drain the pending slot once it is final, or when a newer firing displaces it
  assign move     = pend_vld_r && out_free && (pend_last_r || cmd.fire);

  always_comb begin
    out_vld_nxt    = out_vld_r && !out_ready;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    if (move) begin
      out_vld_nxt    = 1'b1;
      out_status_nxt = pend_status_r;
      out_tag_nxt    = pend_tag_r;
      out_last_nxt   = pend_last_r;
    end

    pend_vld_nxt    = pend_vld_r && !move;
    pend_status_nxt = pend_status_r;
    pend_tag_nxt    = pend_tag_r;
    pend_last_nxt   = pend_last_r;
    if (cmd.single) begin
      pend_vld_nxt    = 1'b1;
      pend_status_nxt = cmd.single_status;
      pend_tag_nxt    = 8'd0;
      pend_last_nxt   = 1'b1;
    end else if (cmd.fire) begin
      pend_vld_nxt    = 1'b1;
      pend_status_nxt = ST_FIRED;
      pend_tag_nxt    = cmd.fire_tag;
      pend_last_nxt   = 1'b0;
    end else if (cmd.finish) begin
      if (pend_vld_r) begin
        pend_last_nxt = 1'b1;
      end else begin
        pend_vld_nxt    = 1'b1;
        pend_status_nxt = ST_NONE;
        pend_tag_nxt    = 8'd0;
        pend_last_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_tag_r    <= pend_tag_nxt;
    pend_last_r   <= pend_last_nxt;
    out_status_r  <= out_status_nxt;
    out_tag_r     <= out_tag_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign st.pend_vld    = pend_vld_r;
  assign st.can_fire    = !pend_vld_r || out_free;

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_fired_tag  = out_tag_r;
  assign out_last       = out_last_r;

endmodule
